>>> rtl/pfe_pkg.sv
package pfe_pkg;

    localparam int LETTER_W  = 5;
    localparam int GRID_DIM  = 5;
    localparam int GRID_CELLS = GRID_DIM * GRID_DIM;
    localparam int CFG_DATA_W = 50;
    localparam int CFG_INDEX_W = 2;

    typedef logic [LETTER_W-1:0] letter_t;
    typedef logic [2:0]          coord_t;
    typedef logic [4:0]          cell_idx_t;
    typedef logic [GRID_CELLS-1:0][LETTER_W-1:0] grid_t;

    localparam letter_t PAD_LETTER  = 5'd23;
    localparam letter_t LETTER_I    = 5'd8;
    localparam letter_t LETTER_J    = 5'd9;
    localparam letter_t LAST_LETTER = 5'd25;
    localparam coord_t  LAST_COORD  = 3'd4;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_GRID_LOW = 2'd0,
        CFG_GRID_MID = 2'd1,
        CFG_GRID_TOP = 2'd2
    } cfg_index_t;

    typedef struct packed {
        letter_t first;
        letter_t second;
    } letter_pair_t;

    typedef struct packed {
        coord_t row;
        coord_t col;
        logic   found;
    } loc_t;

    typedef struct packed {
        loc_t first;
        loc_t second;
    } loc_pair_t;

    typedef struct packed {
        cell_idx_t first;
        cell_idx_t second;
        logic      not_found;
    } cell_pair_t;

    function automatic coord_t wrap_inc(coord_t c);
        return (c == LAST_COORD) ? 3'd0 : c + 3'd1;
    endfunction

    function automatic cell_idx_t cell_index(coord_t row, coord_t col);
        cell_idx_t r5;
        cell_idx_t c5;
        r5 = {2'b00, row};
        c5 = {2'b00, col};
        return (r5 << 2) + r5 + c5;
    endfunction

    function automatic loc_t locate(grid_t grid, letter_t letter);
        loc_t loc;
        loc = '{row: 3'd0, col: 3'd0, found: 1'b0};
        for (int i = GRID_CELLS - 1; i >= 0; i--) begin
            if (grid[i] == letter) begin
                loc.row   = coord_t'(i / GRID_DIM);
                loc.col   = coord_t'(i % GRID_DIM);
                loc.found = 1'b1;
            end
        end
        if (letter > LAST_LETTER) begin
            loc.found = 1'b0;
        end
        return loc;
    endfunction

endpackage

>>> rtl/pfe_locate_stage.sv
module pfe_locate_stage (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  pfe_pkg::grid_t       grid,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  pfe_pkg::letter_pair_t in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output pfe_pkg::loc_pair_t   out_data
);

    logic               valid_reg;
    pfe_pkg::loc_pair_t data_reg;
    pfe_pkg::loc_pair_t data_next;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        data_next.first  = pfe_pkg::locate(grid, in_data.first);
        data_next.second = pfe_pkg::locate(grid, in_data.second);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> rtl/pfe_rule_stage.sv
module pfe_rule_stage (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  pfe_pkg::loc_pair_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output pfe_pkg::cell_pair_t out_data
);

    logic                valid_reg;
    pfe_pkg::cell_pair_t data_reg;
    pfe_pkg::cell_pair_t data_next;
    pfe_pkg::loc_t       a;
    pfe_pkg::loc_t       b;

    assign in_ready = !valid_reg || out_ready;
    assign a = in_data.first;
    assign b = in_data.second;

    always_comb begin
        data_next.not_found = !(a.found && b.found);
        priority if (a.row == b.row) begin
            data_next.first  = pfe_pkg::cell_index(a.row, pfe_pkg::wrap_inc(a.col));
            data_next.second = pfe_pkg::cell_index(b.row, pfe_pkg::wrap_inc(b.col));
        end else if (a.col == b.col) begin
            data_next.first  = pfe_pkg::cell_index(pfe_pkg::wrap_inc(a.row), a.col);
            data_next.second = pfe_pkg::cell_index(pfe_pkg::wrap_inc(b.row), b.col);
        end else begin
            data_next.first  = pfe_pkg::cell_index(a.row, b.col);
            data_next.second = pfe_pkg::cell_index(b.row, a.col);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> rtl/playfair_digram_encrypt_core.sv
// channel  | handshake         | beat payload
// ---------+-------------------+------------------------------------------------
// input    | s_valid / s_ready | s_first_letter, s_second_letter, s_second_present
// result   | m_valid / m_ready | m_cipher_first, m_cipher_second, m_letter_not_found
// config   | cfg_we            | cfg_index, cfg_wdata
//
// four register stages: letter cleanup, grid search, rule select, cell read
// one beat per cycle sustained while m_ready stays high
// a stall on m_ready backs up stage by stage; empty stages still fill
// synchronous active-low reset clears the valid bits and the grid registers
module playfair_digram_encrypt_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [pfe_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [pfe_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [4:0]                         s_first_letter,
    input  logic [4:0]                         s_second_letter,
    input  logic                               s_second_present,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [4:0]                         m_cipher_first,
    output logic [4:0]                         m_cipher_second,
    output logic                               m_letter_not_found
);

    logic [49:0] grid_low_reg;
    logic [49:0] grid_mid_reg;
    logic [24:0] grid_top_reg;
    pfe_pkg::grid_t grid;

    logic                  norm_valid_reg;
    logic                  norm_ready;
    pfe_pkg::letter_pair_t norm_reg;
    pfe_pkg::letter_pair_t norm_next;

    logic               loc_valid;
    logic               loc_ready;
    pfe_pkg::loc_pair_t loc_data;

    logic                rule_valid;
    logic                rule_ready;
    pfe_pkg::cell_pair_t rule_data;

    logic             out_valid_reg;
    logic             out_ready;
    pfe_pkg::letter_t cipher_first_reg;
    pfe_pkg::letter_t cipher_second_reg;
    logic             not_found_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_low_reg <= '0;
            grid_mid_reg <= '0;
            grid_top_reg <= '0;
        end else if (cfg_we) begin
            unique case (pfe_pkg::cfg_index_t'(cfg_index))
                pfe_pkg::CFG_GRID_LOW: grid_low_reg <= cfg_wdata;
                pfe_pkg::CFG_GRID_MID: grid_mid_reg <= cfg_wdata;
                pfe_pkg::CFG_GRID_TOP: grid_top_reg <= cfg_wdata[24:0];
                default: ;
            endcase
        end
    end

    assign grid = {grid_top_reg, grid_mid_reg, grid_low_reg};

    // pad and fold j onto i
    always_comb begin
        norm_next.first  = s_first_letter;
        norm_next.second = s_second_present ? s_second_letter : pfe_pkg::PAD_LETTER;
        if (norm_next.first == pfe_pkg::LETTER_J) begin
            norm_next.first = pfe_pkg::LETTER_I;
        end
        if (norm_next.second == pfe_pkg::LETTER_J) begin
            norm_next.second = pfe_pkg::LETTER_I;
        end
    end

    assign s_ready = !norm_valid_reg || norm_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            norm_valid_reg <= 1'b0;
        end else if (s_ready) begin
            norm_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            norm_reg <= norm_next;
        end
    end

    pfe_locate_stage u_locate (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .grid      (grid),
        .in_valid  (norm_valid_reg),
        .in_ready  (norm_ready),
        .in_data   (norm_reg),
        .out_valid (loc_valid),
        .out_ready (loc_ready),
        .out_data  (loc_data)
    );

    pfe_rule_stage u_rule (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (loc_valid),
        .in_ready  (loc_ready),
        .in_data   (loc_data),
        .out_valid (rule_valid),
        .out_ready (rule_ready),
        .out_data  (rule_data)
    );

    assign out_ready  = !out_valid_reg || m_ready;
    assign rule_ready = out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_ready) begin
            out_valid_reg <= rule_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready && rule_valid) begin
            not_found_reg <= rule_data.not_found;
            if (rule_data.not_found) begin
                cipher_first_reg  <= '0;
                cipher_second_reg <= '0;
            end else begin
                cipher_first_reg  <= grid[rule_data.first];
                cipher_second_reg <= grid[rule_data.second];
            end
        end
    end

    assign m_valid            = out_valid_reg;
    assign m_cipher_first     = cipher_first_reg;
    assign m_cipher_second    = cipher_second_reg;
    assign m_letter_not_found = not_found_reg;

endmodule

>>> rtl/pfe_checker.sv
module pfe_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [4:0] m_cipher_first,
    input logic [4:0] m_cipher_second,
    input logic       m_letter_not_found
);

    // result beat stays offered while stalled
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result beat dropped while stalled");

    a_hold_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_cipher_first) && $stable(m_cipher_second)
            && $stable(m_letter_not_found))
        else $error("result payload changed while stalled");

    a_not_found_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_letter_not_found |-> m_cipher_first == 5'd0
            && m_cipher_second == 5'd0)
        else $error("missing letter with nonzero cipher");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind playfair_digram_encrypt_core pfe_checker u_pfe_checker (.*);
